// ----- rtl/core/shash_pkg.sv -----
// Package: shared types, constants and mixing helpers for the stream hash.
`timescale 1ns / 1ps
package shash_pkg;

  localparam int DefLengthBits = 32;
  localparam int QueueDepth = 4;

  typedef struct packed {
    logic [63:0] data_word;
    logic        first_word;
    logic        last_word;
    logic [31:0] message_length;
  } shash_item_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
    rotl64 = (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] bswap64(input logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 8; i++) y[8*i +: 8] = x[8*(7-i) +: 8];
    bswap64 = y;
  endfunction

endpackage

// ----- rtl/core/shash_ram.sv -----
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module shash_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/shash_front.sv -----
// Front end: input word queue feeding the mixing engine.
`timescale 1ns / 1ps
module shash_front import shash_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  shash_item_t in_item,
  output logic        q_valid,
  input  logic        q_take,
  output shash_item_t q_item
);
  localparam int AW = $clog2(QueueDepth);
  logic [AW-1:0] wr_ptr, rd_ptr, rd_sel;
  logic [AW:0]   count;
  logic          primed;
  logic          push, pop;
  shash_item_t   rdata;

  assign in_ready = (count != QueueDepth[AW:0]);
  assign push = in_valid && in_ready;
  assign pop = q_take && q_valid;
  assign rd_sel = pop ? rd_ptr + 1'b1 : rd_ptr;
  assign q_item = rdata;

  shash_ram #(.WIDTH($bits(shash_item_t)), .DEPTH(QueueDepth)) u_ram (
    .clk(clk), .we(push), .waddr(wr_ptr), .wdata(in_item),
    .raddr(rd_sel), .rdata(rdata)
  );

  // Read data is registered; primed means rdata holds entry rd_ptr.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
      primed <= 1'b0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
      primed <= !pop && !(push && wr_ptr == rd_ptr && count == '0);
    end
  end
  assign q_valid = primed && count != '0;

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk) disable iff (rst)
    count <= QueueDepth[AW:0]) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    count == QueueDepth[AW:0] |-> !in_ready) else $error("ready while full");
`endif
endmodule

// ----- rtl/core/shash_back.sv -----
// Back end: lane, fold and stream mixing over a shared squarer with registered partial products.
`timescale 1ns / 1ps
module shash_back import shash_pkg::*; #(
  parameter int LENGTH_BITS = DefLengthBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] seed_value,
  input  logic        swap_bytes,
  input  logic        q_valid,
  output logic        q_take,
  input  shash_item_t q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash_value
);
  typedef enum logic [3:0] {
    S_IDLE, S_SEED, S_FOLD, S_ABS, S_LMUL, S_SM1, S_SM2, S_SM3, S_SM4,
    S_LAST, S_FM1, S_FM2, S_FM3, S_OUT
  } state_t;

  localparam int LW = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;

  state_t      state;
  shash_item_t it;
  logic [63:0] lane [4];
  logic [63:0] acc, x, word;
  logic [31:0] rem;
  logic [2:0]  pos;
  logic        bulk, tail_taken;
  logic [63:0] mul_a, prod;
  logic [63:0] sq_lo;
  logic [31:0] sq_cross;
  logic        sq_ok, mul_state;
  logic [1:0]  k;
  logic [63:0] len64, s, tv;
  logic [31:0] len_sat;
  logic [63:0] lk, lx, lodd;

  assign k = pos[1:0];
  assign q_take = (state == S_IDLE) && q_valid;
  assign mul_state = state inside {S_LMUL, S_SM1, S_SM3, S_FM1, S_FM2};
  // Low 64 bits of the square: lo*lo plus twice the cross term shifted up.
  assign prod = sq_lo + {sq_cross[30:0], 33'd0};

  always_comb begin
    if (LENGTH_BITS >= 32 || q_item.message_length < (32'd1 << LW))
      len_sat = q_item.message_length;
    else
      len_sat = (32'd1 << LW) - 32'd1;
    len64 = {32'd0, len_sat};
    s = len64 ^ rotl64(len64, 3) ^ rotl64(len64, 47) ^
        seed_value ^ rotl64(seed_value, 23) ^ rotl64(seed_value, 56);
    word = swap_bytes ? bswap64(it.data_word) : it.data_word;
    lk = lane[k];
    lx = lk ^ word;
    case (k)
      2'd0: lodd = 64'd7;
      2'd1: lodd = 64'd11;
      2'd2: lodd = 64'd13;
      default: lodd = 64'd19;
    endcase
    tv = it.data_word;
    if (!swap_bytes) begin
      for (int i = 0; i < 8; i++) if (i >= rem[2:0]) tv[8*i +: 8] = 8'd0;
    end else begin
      tv = 64'd0;
      case (rem[2:0])
        3'd1: tv[7:0] = it.data_word[7:0];
        3'd2, 3'd3: begin
          tv[15:0] = {it.data_word[7:0], it.data_word[15:8]};
          if (rem[2:0] == 3'd3) tv[23:16] = it.data_word[23:16];
        end
        default: begin
          tv[31:0] = {it.data_word[7:0], it.data_word[15:8],
                      it.data_word[23:16], it.data_word[31:24]};
          if (rem[2:0] == 3'd5) tv[39:32] = it.data_word[39:32];
          if (rem[2:0] >= 3'd6) tv[47:32] = {it.data_word[39:32], it.data_word[47:40]};
          if (rem[2:0] == 3'd7) tv[55:48] = it.data_word[55:48];
        end
      endcase
    end
    case (state)
      S_LMUL:  mul_a = lane[k];
      S_SM1:   mul_a = x;
      S_SM3:   mul_a = acc;
      S_FM1, S_FM2: mul_a = x;
      default: mul_a = acc;
    endcase
  end

  function automatic logic [63:0] fold(input logic [63:0] a, input logic [63:0] b,
                                       input logic [63:0] c, input logic [63:0] d);
    fold = (a << 3) - a + (b << 3) + (b << 1) + b + (c << 3) + (c << 2) + c +
           (d << 4) + (d << 1) + d;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < 4; i++) lane[i] <= '0;
      acc <= '0;
      rem <= '0;
      pos <= '0;
      bulk <= 1'b0;
      tail_taken <= 1'b0;
      sq_ok <= 1'b0;
    end else if (mul_state && !sq_ok) begin
      // Hold the state while the partial products are registered.
      sq_lo <= mul_a[31:0] * mul_a[31:0];
      sq_cross <= mul_a[63:32] * mul_a[31:0];
      sq_ok <= 1'b1;
    end else begin
      sq_ok <= 1'b0;
      case (state)
        S_IDLE: if (q_valid) begin
          it <= q_item;
          state <= q_item.first_word ? S_SEED : S_ABS;
          if (q_item.first_word) begin
            lane[0] <= rotl64(s, 11);
            lane[1] <= rotl64(s, 23);
            lane[2] <= rotl64(s, 36);
            lane[3] <= rotl64(s, 50);
            rem <= len_sat;
            pos <= '0;
            tail_taken <= 1'b0;
            bulk <= len_sat >= 32'd64;
          end
        end
        S_SEED: state <= bulk ? S_ABS : S_FOLD;
        S_FOLD: begin
          acc <= fold(lane[0], lane[1], lane[2], lane[3]);
          state <= S_ABS;
        end
        S_ABS: begin
          if (rem == '0) state <= S_LAST;
          else if (bulk) begin
            lane[k] <= pos[2] ? lx ^ (lx >> 37) : lx;
            state <= pos[2] ? S_SM4 : S_LMUL;
          end else begin
            x <= (rem >= 32'd8) ? word : tv;
            state <= S_SM1;
          end
        end
        S_LMUL: begin
          lane[k] <= lane[k] ^ (prod | lodd);
          state <= S_SM4;
        end
        S_SM4: begin
          if (pos == 3'd7) begin
            pos <= '0;
            rem <= rem - 32'd64;
            if (rem - 32'd64 < 32'd64) begin
              bulk <= 1'b0;
              acc <= fold(lane[0], lane[1], lane[2], lane[3]);
            end
          end else begin
            pos <= pos + 3'd1;
          end
          state <= S_LAST;
        end
        S_SM1: begin
          x <= x ^ (prod | 64'd7);
          state <= S_SM2;
        end
        S_SM2: begin
          acc <= acc + {x[26:0], x[63:27]};
          state <= S_SM3;
        end
        S_SM3: begin
          acc <= (acc ^ (prod | 64'd7)) ^ ((acc ^ (prod | 64'd7)) >> 27);
          if (rem >= 32'd8) rem <= rem - 32'd8;
          else begin
            rem <= '0;
            tail_taken <= 1'b1;
          end
          state <= S_LAST;
        end
        S_LAST: begin
          if (!it.last_word) state <= S_IDLE;
          else if (tail_taken) begin
            hash_value <= swap_bytes ? bswap64(acc) : acc;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            x <= bulk ? fold(lane[0], lane[1], lane[2], lane[3]) : acc;
            state <= S_FM1;
          end
        end
        S_FM1: begin
          x <= {(x ^ (prod | 64'd7))} >> 27 | ((x ^ (prod | 64'd7)) << 37);
          state <= S_FM2;
        end
        S_FM2: begin
          hash_value <= swap_bytes ?
            bswap64((x ^ (prod | 64'd7)) ^ ((x ^ (prod | 64'd7)) >> 27)) :
            (x ^ (prod | 64'd7)) ^ ((x ^ (prod | 64'd7)) >> 27);
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hash_value))
    else $error("result dropped");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    q_take |-> state == S_IDLE) else $error("take while busy");
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("valid outside output");
`endif
endmodule

// ----- rtl/core/seeded_64bit_stream_hash.sv -----
// Top level: seeded 64-bit stream hash over 64-bit message words.
//
// Input channel (in_valid/in_ready) takes one word per handshake with
// first_word, last_word and message_length; byte_count is unused. A
// four-entry queue decouples intake from the mixing engine, so words keep
// arriving while a hash waits on out_valid/out_ready.
// Every squaring registers the 32-bit partial products, then uses their sum.
// A word past the message length goes straight to the last-word check; a
// bulk word either xor-shifts its lane or squares it; a stream word is
// squared and added to the accumulator, which is then squared. A first
// word seeds the lanes first and, outside bulk mode, folds them. Without
// an absorbed tail, the final mix squares twice more.
// Configuration: cfg_we with cfg_index 0 writes the seed, 1 the swap mode.
// Reset clears the queue, lanes, accumulator and counters at once.
// A stalled receiver holds hash_value; the queue fills and in_ready drops.
`timescale 1ns / 1ps
module seeded_64bit_stream_hash import shash_pkg::*; #(
  parameter int LENGTH_BITS = DefLengthBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        first_word,
  input  logic        last_word,
  input  logic [31:0] message_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash_value
);
  logic [63:0] seed_value;
  logic        swap_bytes;
  shash_item_t in_item, q_item;
  logic        q_valid, q_take;
  logic [3:0]  unused_count;

  assign unused_count = byte_count;
  assign in_item = '{data_word: data_word, first_word: first_word,
                     last_word: last_word, message_length: message_length};

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= '0;
      swap_bytes <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) seed_value <= cfg_data;
      else swap_bytes <= cfg_data[0];
    end
  end

  shash_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
  );

  shash_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk(clk), .rst(rst), .seed_value(seed_value), .swap_bytes(swap_bytes),
    .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
    .out_valid(out_valid), .out_ready(out_ready), .hash_value(hash_value)
  );
endmodule
